// ===== sv/scmd_pkg.sv =====
package scmd_pkg;

    localparam int PHASE_W = 7;
    localparam int SHIFT_W = 33;
    localparam int BT_W    = 16;
    localparam int SEL_W   = 5;
    localparam int CMD_W   = 6;

    // Receive phases: per byte b, 11*b waits for the start edge, 11*b+1 re-checks
    // the start bit, the rest shift in bits. Transmit runs from PH_TX to PH_TX_END.
    localparam logic [PHASE_W-1:0] PH_IDLE0   = 7'd0;
    localparam logic [PHASE_W-1:0] PH_START0  = 7'd1;
    localparam logic [PHASE_W-1:0] PH_IDLE1   = 7'd11;
    localparam logic [PHASE_W-1:0] PH_START1  = 7'd12;
    localparam logic [PHASE_W-1:0] PH_IDLE2   = 7'd22;
    localparam logic [PHASE_W-1:0] PH_START2  = 7'd23;
    localparam logic [PHASE_W-1:0] PH_TX      = 7'd33;
    localparam logic [PHASE_W-1:0] PH_TX_END  = 7'd64;
    localparam logic [PHASE_W-1:0] PH_RESET   = 7'd65;

    localparam logic [SHIFT_W-1:0] RX_MSB      = 33'h100;
    localparam logic [SHIFT_W-1:0] SYNC_FRAME  = 33'h155;
    localparam logic [SHIFT_W-1:0] CMD_LIMIT   = 33'h121;
    localparam logic [CMD_W-1:0]   CMD_READ    = 6'h20;
    localparam logic [9:0]         REPLY_FRAME = 10'h3AA;  // 0xAA with two stop bits
    localparam logic [9:0]         STOP_BITS   = 10'h300;

    localparam logic [BT_W-1:0]  BIT_TIME_RESET = 16'd1600;
    localparam logic [BT_W-1:0]  BIT_TIME_MIN   = 16'd2;
    localparam logic [SEL_W-1:0] SETTING_RESET  = 5'd0;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_TIME = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_SEL = 1'd1;

    typedef struct packed {
        logic kind;
        logic line_level;
    } in_item_t;

    typedef struct packed {
        logic             line_out;
        logic [SEL_W-1:0] setting;
        logic             save_request;
        logic             reset_request;
    } out_item_t;

    typedef struct packed {
        logic     valid;
        in_item_t item;
    } held_req_t;

endpackage

// ===== sv/scmd_in_stage.sv =====
module scmd_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  scmd_pkg::in_item_t  in_data,
    input  logic                advance,
    output scmd_pkg::held_req_t held
);
    import scmd_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_data;
        end
    end

    assign held.valid = valid_reg;
    assign held.item  = item_reg;

endmodule

// ===== sv/scmd_core.sv =====
module scmd_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [scmd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [scmd_pkg::BT_W-1:0]            cfg_wdata,
    input  logic                                 advance,
    input  scmd_pkg::in_item_t                   item,
    output scmd_pkg::out_item_t                  result
);
    import scmd_pkg::*;

    logic [BT_W-1:0]    bit_time_reg;
    logic [PHASE_W-1:0] phase_reg,   phase_next;
    logic [SHIFT_W-1:0] shift_reg,   shift_next;
    logic [BT_W-1:0]    timer_reg,   timer_next;
    logic [CMD_W-1:0]   held_cmd_reg, held_cmd_next;
    logic               last_reg,    last_next;
    logic [SEL_W-1:0]   setting_reg, setting_next;
    logic               drive_reg,   drive_next;

    logic [BT_W-1:0]    eff_bt;
    logic [BT_W-1:0]    half_bt;
    logic               idle;
    logic               start_check;
    logic [PHASE_W-1:0] phase_inc;
    logic [SHIFT_W-1:0] rx_shift;
    logic [9:0]         set_frame;
    logic               save;
    logic               rst_pulse;

    assign eff_bt      = (bit_time_reg < BIT_TIME_MIN) ? BIT_TIME_MIN : bit_time_reg;
    assign half_bt     = eff_bt >> 1;
    assign idle        = (phase_reg == PH_IDLE0) || (phase_reg == PH_IDLE1)
                      || (phase_reg == PH_IDLE2);
    assign start_check = (phase_reg == PH_START0) || (phase_reg == PH_START1)
                      || (phase_reg == PH_START2);
    assign phase_inc   = phase_reg + 7'd1;
    assign rx_shift    = (shift_reg >> 1) + (last_reg ? RX_MSB : '0);
    assign set_frame   = {5'd0, setting_reg} + STOP_BITS;

    always_comb
    begin
        phase_next    = phase_reg;
        shift_next    = shift_reg;
        timer_next    = timer_reg;
        held_cmd_next = held_cmd_reg;
        last_next     = last_reg;
        setting_next  = setting_reg;
        drive_next    = drive_reg;
        save          = 1'b0;
        rst_pulse     = 1'b0;

        if (!item.kind)
        begin
            if (!idle)
            begin
                if (timer_reg > 16'd1)
                begin
                    timer_next = timer_reg - 16'd1;
                end
                else
                begin
                    timer_next = '0;
                    if (start_check)
                    begin
                        if (last_reg)
                        begin
                            phase_next = PH_IDLE0;
                        end
                        else
                        begin
                            phase_next = phase_inc;
                            timer_next = eff_bt;
                        end
                    end
                    else if (phase_reg < PH_TX)
                    begin
                        shift_next = rx_shift;
                        phase_next = phase_inc;
                        if (phase_inc == PH_IDLE1 || phase_inc == PH_IDLE2 || phase_inc == PH_TX)
                        begin
                            // end of a byte: stop bit, then frame checks
                            if (!rx_shift[8])
                            begin
                                phase_next = PH_IDLE0;
                            end
                            else if (phase_inc == PH_IDLE1)
                            begin
                                if (rx_shift != SYNC_FRAME)
                                begin
                                    phase_next = PH_IDLE0;
                                end
                            end
                            else if (phase_inc == PH_IDLE2)
                            begin
                                if (rx_shift >= CMD_LIMIT)
                                begin
                                    phase_next = PH_IDLE0;
                                end
                                else
                                begin
                                    held_cmd_next = rx_shift[CMD_W-1:0];
                                end
                            end
                            else if ({2'b00, held_cmd_reg} != rx_shift[7:0])
                            begin
                                phase_next = PH_IDLE0;
                            end
                            else if (held_cmd_reg < CMD_READ)
                            begin
                                if (setting_reg != held_cmd_reg[SEL_W-1:0])
                                begin
                                    setting_next = held_cmd_reg[SEL_W-1:0];
                                    save         = 1'b1;
                                end
                                phase_next = PH_RESET;
                                timer_next = 16'd1;
                            end
                            else
                            begin
                                // reply: 0xAA, setting, setting; LSB first after a start bit
                                shift_next = {set_frame, 1'b0, set_frame, 1'b0, REPLY_FRAME, 1'b0};
                                phase_next = PH_TX;
                                timer_next = 16'd1;
                            end
                        end
                        else
                        begin
                            timer_next = eff_bt;
                        end
                    end
                    else if (phase_reg == PH_RESET)
                    begin
                        rst_pulse  = 1'b1;
                        phase_next = PH_IDLE0;
                        drive_next = 1'b1;
                    end
                    else if (phase_reg == PH_TX_END)
                    begin
                        phase_next = PH_IDLE0;
                        drive_next = 1'b1;
                    end
                    else
                    begin
                        drive_next = shift_reg[0];
                        shift_next = shift_reg >> 1;
                        timer_next = (phase_reg == PH_TX) ? half_bt : eff_bt;
                        phase_next = phase_inc;
                    end
                end
            end
        end
        else
        begin
            if (idle && last_reg && !item.line_level)
            begin
                phase_next = phase_inc;
                timer_next = half_bt;
            end
            last_next = item.line_level;
        end
    end

    assign result.line_out      = drive_next;
    assign result.setting       = setting_next;
    assign result.save_request  = save;
    assign result.reset_request = rst_pulse;

    // initial_selection only seeds the setting at reset; its reset value is
    // SETTING_RESET, so a write to it has no visible effect.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_time_reg <= BIT_TIME_RESET;
        end
        else if (cfg_wr_en && cfg_index == CFG_BIT_TIME)
        begin
            bit_time_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE0;
            shift_reg    <= '0;
            timer_reg    <= '0;
            held_cmd_reg <= '0;
            last_reg     <= 1'b1;
            setting_reg  <= SETTING_RESET;
            drive_reg    <= 1'b1;
        end
        else if (advance)
        begin
            phase_reg    <= phase_next;
            shift_reg    <= shift_next;
            timer_reg    <= timer_next;
            held_cmd_reg <= held_cmd_next;
            last_reg     <= last_next;
            setting_reg  <= setting_next;
            drive_reg    <= drive_next;
        end
    end

endmodule

// ===== sv/scmd_out_stage.sv =====
module scmd_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  scmd_pkg::out_item_t result,
    output logic                slot_free,
    output logic                out_valid,
    input  logic                out_ready,
    output scmd_pkg::out_item_t out_data
);
    import scmd_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_item_t data_reg;

    assign slot_free  = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== sv/serial_os_selector_command_port.sv =====
// A request accepted into the input register passes through the state update into
// the result register, which loads once the result slot is free.
// Throughput: one request per cycle while the result slot is free; the state update
// is a single pass of logic between the input register and the result register.
// Reset (rst_n, async, active low): receiver idle, line released, bit time 1600,
// setting 0, both channels empty.
module serial_os_selector_command_port (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  scmd_pkg::in_item_t             in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output scmd_pkg::out_item_t            out_data,
    input  logic                           cfg_wr_en,
    input  logic [scmd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [scmd_pkg::BT_W-1:0]      cfg_wdata
);
    import scmd_pkg::*;

    held_req_t held;
    out_item_t result;
    logic      slot_free;
    logic      advance;

    assign advance = held.valid && slot_free;

    scmd_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .advance  (advance),
        .held     (held)
    );

    scmd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .advance   (advance),
        .item      (held.item),
        .result    (result)
    );

    scmd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .result    (result),
        .slot_free (slot_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== sv/scmd_checker.sv =====
module scmd_props (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input scmd_pkg::in_item_t             in_data,
    input logic                           out_valid,
    input logic                           out_ready,
    input scmd_pkg::out_item_t            out_data,
    input logic                           cfg_wr_en,
    input logic [scmd_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [scmd_pkg::BT_W-1:0]      cfg_wdata
);
    import scmd_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // input only stalls when the result slot is full and blocked
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled with free result slot");

    // save ends the write frame, reset pulse comes one tick later
    a_save_rst: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.save_request && out_data.reset_request))
        else $error("save and reset requests in one result");

    // the reset pulse follows a write, never a transmit
    a_rst_line: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.reset_request |-> out_data.line_out)
        else $error("line driven low during reset request");

endmodule

bind serial_os_selector_command_port scmd_props u_scmd_props (.*);

// ===== test/scmd_checker.sv =====
module scmd_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  scmd_pkg::in_item_t             in_data,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  scmd_pkg::out_item_t            out_data,
    input  logic                           cfg_wr_en,
    input  logic [scmd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [scmd_pkg::BT_W-1:0]      cfg_wdata,
    output int                             mismatch_count,
    output int                             pending_outputs
);
    import scmd_pkg::*;

    // Shadow copy of the port state
    logic [PHASE_W-1:0] rx_phase;
    logic [SHIFT_W-1:0] shifter;
    logic [BT_W-1:0]    bit_count;
    logic [CMD_W-1:0]   cmd_latch;
    logic               line_seen;
    logic [SEL_W-1:0]   sel_value;
    logic               drive_out;
    logic               save_flag;
    logic               reset_flag;

    logic [BT_W-1:0]    cfg_bit_time;
    logic [SEL_W-1:0]   cfg_init_sel;

    out_item_t          expected_outputs[$];
    out_item_t          predicted;
    out_item_t          oldest;

    function automatic logic [BT_W-1:0] bit_period();
        return (cfg_bit_time < BIT_TIME_MIN) ? BIT_TIME_MIN : cfg_bit_time;
    endfunction

    task automatic close_byte();
        logic [9:0] setting_word;
        if (!shifter[8])
        begin
            rx_phase = PH_IDLE0;    // stop bit low
        end
        else if (rx_phase == PH_IDLE1)
        begin
            if (shifter != SYNC_FRAME)
                rx_phase = PH_IDLE0;
        end
        else if (rx_phase == PH_IDLE2)
        begin
            if (shifter >= CMD_LIMIT)
                rx_phase = PH_IDLE0;
            else
                cmd_latch = shifter[CMD_W-1:0];
        end
        else if ({2'b00, cmd_latch} != shifter[7:0])
        begin
            rx_phase = PH_IDLE0;    // repeat does not match
        end
        else if (cmd_latch < CMD_READ)
        begin
            if (sel_value != cmd_latch[SEL_W-1:0])
            begin
                sel_value = cmd_latch[SEL_W-1:0];
                save_flag = 1'b1;
            end
            rx_phase  = PH_RESET;
            bit_count = 16'd1;
        end
        else
        begin
            // reply: 0xAA, setting, setting, each with two stop bits
            setting_word = STOP_BITS | {5'b0, sel_value};
            shifter = ({23'b0, REPLY_FRAME} << 1) | ({23'b0, setting_word} << 12)
                    | ({23'b0, setting_word} << 23);
            rx_phase  = PH_TX;
            bit_count = 16'd1;
        end
    endtask

    task automatic bit_boundary();
        if (rx_phase == PH_START0 || rx_phase == PH_START1 || rx_phase == PH_START2)
        begin
            if (line_seen)
                rx_phase = PH_IDLE0;
            else
            begin
                rx_phase  = rx_phase + 7'd1;
                bit_count = bit_period();
            end
        end
        else if (rx_phase < PH_TX)
        begin
            shifter  = (shifter >> 1) + (line_seen ? RX_MSB : '0);
            rx_phase = rx_phase + 7'd1;
            if (rx_phase == PH_IDLE1 || rx_phase == PH_IDLE2 || rx_phase == PH_TX)
                close_byte();
            else
                bit_count = bit_period();
        end
        else if (rx_phase == PH_RESET)
        begin
            reset_flag = 1'b1;
            rx_phase   = PH_IDLE0;
            drive_out  = 1'b1;
        end
        else if (rx_phase == PH_TX_END)
        begin
            rx_phase  = PH_IDLE0;
            drive_out = 1'b1;
        end
        else
        begin
            drive_out = shifter[0];
            shifter   = shifter >> 1;
            // first start bit of the reply is half width
            bit_count = (rx_phase == PH_TX) ? (bit_period() >> 1) : bit_period();
            rx_phase  = rx_phase + 7'd1;
        end
    endtask

    task automatic compute_port_output(input in_item_t req, output out_item_t res);
        logic waiting;
        save_flag  = 1'b0;
        reset_flag = 1'b0;
        waiting = (rx_phase == PH_IDLE0) || (rx_phase == PH_IDLE1) || (rx_phase == PH_IDLE2);
        if (!req.kind)
        begin
            if (!waiting)
            begin
                if (bit_count > 1)
                    bit_count = bit_count - 16'd1;
                else
                begin
                    bit_count = 0;
                    bit_boundary();
                end
            end
        end
        else
        begin
            if (waiting && line_seen && !req.line_level)
            begin
                rx_phase  = rx_phase + 7'd1;
                bit_count = bit_period() >> 1;
            end
            line_seen = req.line_level;
        end
        res.line_out      = drive_out;
        res.setting       = sel_value;
        res.save_request  = save_flag;
        res.reset_request = reset_flag;
    endtask

    task automatic flag_failure(input string msg);
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= 10)
            $display("%s", msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_phase       = PH_IDLE0;
            shifter        = '0;
            bit_count      = '0;
            cmd_latch      = '0;
            line_seen      = 1'b1;
            cfg_bit_time   = BIT_TIME_RESET;
            cfg_init_sel   = SETTING_RESET;
            sel_value      = cfg_init_sel;
            drive_out      = 1'b1;
            mismatch_count = 0;
            expected_outputs.delete();
            pending_outputs <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == CFG_BIT_TIME)
                    cfg_bit_time = cfg_wdata;
                else if (cfg_index == CFG_INIT_SEL)
                    cfg_init_sel = cfg_wdata[SEL_W-1:0];
            end

            if (out_valid && out_ready)
            begin
                if (expected_outputs.size() == 0)
                begin
                    flag_failure($sformatf("unexpected output: line=%0b set=%0d save=%0b rst=%0b",
                        out_data.line_out, out_data.setting, out_data.save_request,
                        out_data.reset_request));
                end
                else
                begin
                    oldest = expected_outputs.pop_front();
                    if (out_data.line_out !== oldest.line_out
                        || out_data.setting !== oldest.setting
                        || out_data.save_request !== oldest.save_request
                        || out_data.reset_request !== oldest.reset_request)
                    begin
                        flag_failure($sformatf({"output mismatch: expected line=%0b set=%0d ",
                            "save=%0b rst=%0b, got line=%0b set=%0d save=%0b rst=%0b"},
                            oldest.line_out, oldest.setting, oldest.save_request,
                            oldest.reset_request, out_data.line_out, out_data.setting,
                            out_data.save_request, out_data.reset_request));
                    end
                end
            end

            if (in_valid && in_ready)
            begin
                compute_port_output(in_data, predicted);
                expected_outputs.push_back(predicted);
            end

            pending_outputs <= expected_outputs.size();
        end
    end

endmodule

// ===== test/tb_serial_os_selector_command_port.sv =====
module tb_serial_os_selector_command_port;
    import scmd_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int REQUEST_GOAL = 1300;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    in_item_t             in_data   = '0;
    logic                 out_ready = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_BIT_TIME;
    logic [BT_W-1:0]      cfg_wdata = '0;

    logic                 in_ready;
    logic                 out_valid;
    out_item_t            out_data;
    int                   mismatch_count;
    int                   pending_outputs;

    int                   cycle_count   = 0;
    int                   requests_sent = 0;
    int                   period_ticks  = 2;
    int                   stall_left    = 0;
    int                   stall_draw;
    bit                   calm          = 1'b0;
    logic                 host_line     = 1'b1;

    serial_os_selector_command_port uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    scmd_checker port_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_data        (out_data),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .mismatch_count  (mismatch_count),
        .pending_outputs (pending_outputs)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side: after each accepted result, hold ready low for a random stretch
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end
        else if (out_valid && out_ready)
        begin
            stall_draw = calm ? 0 : $urandom_range(0, 10);
            stall_left <= stall_draw;
            out_ready  <= (stall_draw == 0);
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= (stall_left == 1);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Entered and left on a rising edge; valid stays high after acceptance
    task automatic push_request(input logic kind, input logic lvl);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 10);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= {kind, lvl};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        requests_sent++;
        if (kind)
            host_line = lvl;
    endtask

    // line level on a tick request is don't-care, so randomize it
    task automatic tick();
        push_request(1'b0, 1'($urandom_range(0, 1)));
    endtask

    task automatic ticks(input int n);
        repeat (n) tick();
    endtask

    task automatic drive_line(input logic lvl);
        push_request(1'b1, lvl);
    endtask

    task automatic drain_outputs();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_outputs != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input logic [BT_W-1:0] bt, input logic [SEL_W-1:0] sel);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_BIT_TIME;
        cfg_wdata <= bt;
        @(posedge clk);
        cfg_index <= CFG_INIT_SEL;
        cfg_wdata <= {{(BT_W-SEL_W){1'b0}}, sel};
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        period_ticks = int'((bt < BIT_TIME_MIN) ? BIT_TIME_MIN : bt);
    endtask

    // One host frame: start edge, half-bit wait, eight data bits LSB first, stop bit
    task automatic send_frame(input logic [7:0] value, input logic stop, input bit glitch);
        int   i;
        logic b;
        if (!host_line)
            drive_line(1'b1);
        if ($urandom_range(0, 3) == 0)
            tick();
        drive_line(1'b0);
        if (glitch)
        begin
            drive_line(1'b1);   // line back high before the start check
            ticks(period_ticks / 2);
        end
        else
        begin
            ticks(period_ticks / 2);
            for (i = 0; i < 9; i++)
            begin
                b = (i < 8) ? value[i] : stop;
                if (b != host_line || $urandom_range(0, 7) == 0)
                    drive_line(b);
                ticks(period_ticks);
            end
        end
    endtask

    // Three frames; the frame at fail_at gets a low stop bit or a bad start
    task automatic send_sequence(input logic [7:0] b0, input logic [7:0] b1,
                                 input logic [7:0] b2, input int fail_at, input bit bad_start);
        int         f;
        bit         aborted;
        logic [7:0] value;
        aborted = 1'b0;
        for (f = 0; f < 3 && !aborted; f++)
        begin
            value = (f == 0) ? b0 : ((f == 1) ? b1 : b2);
            if (f == fail_at)
            begin
                send_frame(value, bad_start, bad_start);
                aborted = 1'b1;
            end
            else
            begin
                send_frame(value, 1'b1, 1'b0);
            end
        end
    endtask

    task automatic run_command_scenario();
        int         pick;
        int         span;
        logic [7:0] sync_byte;
        logic [7:0] read_cmd;
        logic [7:0] cmd;
        logic [7:0] other;
        pick      = $urandom_range(0, 99);
        sync_byte = SYNC_FRAME[7:0];
        read_cmd  = {2'b00, CMD_READ};
        cmd       = 8'($urandom_range(0, 31));
        if (pick < 40)
        begin
            send_sequence(sync_byte, cmd, cmd, 3, 1'b0);
            if ($urandom_range(0, 3) == 0)
                drive_line(1'($urandom_range(0, 1)));   // line moves while reset is pending
            ticks($urandom_range(1, 3));
        end
        else if (pick < 60)
        begin
            send_sequence(sync_byte, read_cmd, read_cmd, 3, 1'b0);
            span = 2 + period_ticks / 2 + 31 * period_ticks;
            ticks(span / 2);
            if ($urandom_range(0, 2) == 0)
                drive_line(1'($urandom_range(0, 1)));   // host wiggles the line during reply
            ticks(span - span / 2);
        end
        else if (pick < 65)
        begin
            do
                other = 8'($urandom_range(0, 255));
            while (other == sync_byte);
            send_sequence(other, cmd, cmd, 3, 1'b0);
        end
        else if (pick < 70)
        begin
            other = ($urandom_range(0, 1) != 0) ? read_cmd + 8'd1
                                                : 8'($urandom_range(33, 255));
            send_sequence(sync_byte, other, other, 3, 1'b0);
        end
        else if (pick < 75)
        begin
            cmd = 8'($urandom_range(0, 32));
            do
                other = 8'($urandom_range(0, 255));
            while (other == cmd);
            send_sequence(sync_byte, cmd, other, 3, 1'b0);
        end
        else if (pick < 80)
        begin
            send_sequence(sync_byte, cmd, cmd, $urandom_range(0, 2), 1'b0);
        end
        else if (pick < 85)
        begin
            send_sequence(sync_byte, cmd, cmd, $urandom_range(0, 2), 1'b1);
        end
        else
        begin
            repeat ($urandom_range(1, 8))
                push_request(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            // line high and enough ticks to flush any frame the noise started
            if (!host_line)
                drive_line(1'b1);
            ticks(10 * period_ticks + 2);
        end
    endtask

    initial
    begin : stimulus
        int              phase_idx;
        int              bt_pick;
        logic [BT_W-1:0] bt;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: bit time below minimum, setting register written but unused
        set_config(16'd0, 5'd31);
        tick();
        drive_line(1'b1);       // no change, no edge
        tick();
        drive_line(1'b0);       // start edge
        drive_line(1'b0);       // same level again
        drive_line(1'b1);       // high before the start check
        tick();                 // start check fails
        drive_line(1'b0);
        tick();                 // start check passes
        drive_line(1'b1);
        ticks(18);              // all-ones byte, not a sync frame
        drain_outputs();

        phase_idx = 0;
        while (requests_sent < REQUEST_GOAL)
        begin
            bt_pick = $urandom_range(0, 9);
            if (phase_idx == 0)
                bt = 16'd1;
            else if (bt_pick == 0)
                bt = 16'd0;
            else if (bt_pick == 1)
                bt = 16'd1;
            else if (bt_pick < 6)
                bt = 16'd2;
            else if (bt_pick < 8)
                bt = 16'd3;
            else if (bt_pick == 8)
                bt = 16'($urandom_range(4, 6));
            else
                bt = 16'($urandom_range(7, 12));
            calm = ($urandom_range(0, 3) == 0);
            set_config(bt, 5'($urandom_range(0, 31)));
            repeat ($urandom_range(2, 5))
                run_command_scenario();
            drain_outputs();
            phase_idx++;
        end

        // Long odd bit time: one failed start check after a full half-bit wait
        calm = 1'b1;
        set_config(16'd201, 5'd31);
        if (!host_line)
            drive_line(1'b1);
        drive_line(1'b0);
        drive_line(1'b1);
        ticks(100);
        drain_outputs();

        calm = 1'b0;
        set_config(16'd2, 5'd0);
        run_command_scenario();
        run_command_scenario();
        drain_outputs();
        repeat (10) @(posedge clk);

        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== serial_os_selector_command_port.f =====
sv/scmd_pkg.sv
sv/scmd_in_stage.sv
sv/scmd_core.sv
sv/scmd_out_stage.sv
sv/serial_os_selector_command_port.sv
sv/scmd_checker.sv
test/scmd_checker.sv
test/tb_serial_os_selector_command_port.sv
